// ===== rtl/rcfc_pkg.sv =====
// ----------------------------------------------------------------------------
// rcfc_pkg: shared types and constants of the rc frame conditioner
// payload structs, register indexes, reject codes and the queue entry type
// ----------------------------------------------------------------------------
package rcfc_pkg;

  localparam int unsigned OneQ14     = 16384;
  localparam int unsigned RangeLimit = 16386;

  // register indexes
  localparam logic [2:0] RegDeadZone  = 3'd0;
  localparam logic [2:0] RegModeThr   = 3'd1;
  localparam logic [2:0] RegGearThr   = 3'd2;
  localparam logic [2:0] RegPChan     = 3'd3;
  localparam logic [2:0] RegIChan     = 3'd4;
  localparam logic [2:0] RegDChan     = 3'd5;
  localparam logic [2:0] RegModeChan  = 3'd6;
  localparam logic [2:0] RegGearChan  = 3'd7;

  // reject codes
  localparam logic [2:0] RejNone   = 3'd0;
  localparam logic [2:0] RejLost   = 3'd1;
  localparam logic [2:0] RejIndex  = 3'd2;
  localparam logic [2:0] RejCount  = 3'd3;
  localparam logic [2:0] RejStick  = 3'd4;
  localparam logic [2:0] RejMapped = 3'd5;

  typedef struct packed {
    logic [4:0]         channel_index;
    logic signed [15:0] channel_value;
    logic               value_finite;
    logic               link_lost;
    logic [4:0]         claimed_count;
    logic               frame_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         reject_reason;
    logic signed [15:0] stick_0;
    logic signed [15:0] stick_1;
    logic signed [15:0] stick_2;
    logic signed [15:0] stick_3;
    logic [14:0]        p_level;
    logic [14:0]        i_level;
    logic [14:0]        d_level;
    logic               hover_active;
    logic               hover_entered;
    logic               offboard_active;
    logic               offboard_entered;
  } out_item_t;

  // classified frame-close job handed from front to back
  typedef struct packed {
    logic       lost;
    logic [4:0] count;
  } job_t;

endpackage

// ===== rtl/rcfc_job_fifo.sv =====
// ----------------------------------------------------------------------------
// rcfc_job_fifo: two-entry queue of frame-close jobs
// decouples the item front end from the frame evaluator
// ----------------------------------------------------------------------------
module rcfc_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rcfc_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output rcfc_pkg::job_t data_o
);
  import rcfc_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wr_q <= ~wr_q;
      if (pop_i && !empty_o) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && !empty_o);
    end
  end
endmodule

// ===== rtl/rcfc_divider.sv =====
// ----------------------------------------------------------------------------
// rcfc_divider: restoring divider, one quotient bit per cycle
// unsigned 29-bit dividend over 15-bit divisor
// ----------------------------------------------------------------------------
module rcfc_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [28:0] num_i,
  input  logic [14:0] den_i,
  output logic        done_o,
  output logic [28:0] quo_o
);
  logic [28:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [14:0] den_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic [15:0] trial;

  assign quo_o = quo_q;

  always_comb begin
    trial = {rem_q[14:0], quo_q[28]};
    if (trial >= {1'b0, den_q}) begin
      rem_d = trial - {1'b0, den_q};
      quo_d = {quo_q[27:0], 1'b1};
    end else begin
      rem_d = trial;
      quo_d = {quo_q[27:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i; rem_q <= '0; den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= quo_d; rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1; cnt_q <= 5'd28;
      end else if (busy_q) begin
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0; done_o <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end
endmodule

// ===== rtl/rcfc_evaluator.sv =====
// ----------------------------------------------------------------------------
// rcfc_evaluator: frame checker and conditioner
// walks checks slot by slot, dead-zones sticks through a shared divider
// ----------------------------------------------------------------------------
module rcfc_evaluator #(
  parameter int unsigned MaxChannels = 18,
  parameter int unsigned StickCount  = 4,
  localparam int unsigned IdxW = $clog2(MaxChannels)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  input  rcfc_pkg::job_t        job_i,
  output logic                  job_pop_o,
  output logic [IdxW-1:0]       rd_idx_o,
  input  logic signed [15:0]    rd_value_i,
  input  logic                  rd_finite_i,
  input  logic [13:0]           dead_zone_i,
  input  logic signed [15:0]    mode_thr_i,
  input  logic signed [15:0]    gear_thr_i,
  input  logic [4:0]            p_chan_i,
  input  logic [4:0]            i_chan_i,
  input  logic [4:0]            d_chan_i,
  input  logic [4:0]            mode_chan_i,
  input  logic [4:0]            gear_chan_i,
  output logic                  res_valid_o,
  output rcfc_pkg::out_item_t   res_o,
  input  logic                  res_ready_i
);
  import rcfc_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;
  localparam int unsigned NSteps = StickCount + 5;
  localparam int unsigned StepW  = $clog2(NSteps + 1);

  logic [2:0]       state_q;
  logic [StepW-1:0] step_q;
  out_item_t        res_q;
  logic signed [15:0] prev_mode_q, prev_gear_q;
  logic             mode_seen_q, gear_seen_q;
  logic signed [15:0] mode_val_q;
  logic             neg_q;
  logic [4:0]       slot;
  logic [4:0]       max_mapped;
  logic             idx_bad;
  logic [5:0]       need;
  logic [2:0]       early_rsn;
  out_item_t        rej_res;
  logic             in_range;
  logic signed [16:0] v17, dz17;
  logic [28:0]      div_num;
  logic [14:0]      div_den;
  logic             div_start, div_done;
  logic [28:0]      div_quo;
  logic [15:0]      mag;
  logic [15:0]      stick_val;
  logic [16:0]      knob_sum;
  logic [14:0]      knob;
  logic signed [15:0] pm, pg;
  logic             hov, off;

  // slot visited by each step: sticks first, then p, i, d, mode, gear
  always_comb begin
    slot = 5'(step_q);
    if (step_q >= StepW'(StickCount)) begin
      unique case (32'(step_q) - StickCount)
        0: slot = p_chan_i;
        1: slot = i_chan_i;
        2: slot = d_chan_i;
        3: slot = mode_chan_i;
        default: slot = gear_chan_i;
      endcase
    end
  end
  assign rd_idx_o = IdxW'(slot);

  always_comb begin
    max_mapped = p_chan_i;
    if (i_chan_i > max_mapped) max_mapped = i_chan_i;
    if (d_chan_i > max_mapped) max_mapped = d_chan_i;
    if (mode_chan_i > max_mapped) max_mapped = mode_chan_i;
    if (gear_chan_i > max_mapped) max_mapped = gear_chan_i;
    idx_bad = (32'(max_mapped) >= MaxChannels);
    need = 6'(max_mapped) + 6'd1;
    if (need < 6'(StickCount)) need = 6'(StickCount);
  end

  // checks on the job itself in priority order, and the reject result
  always_comb begin
    early_rsn = RejNone;
    if (job_i.lost) early_rsn = RejLost;
    else if (idx_bad) early_rsn = RejIndex;
    else if (32'(job_i.count) > MaxChannels || 6'(job_i.count) < need)
      early_rsn = RejCount;
    rej_res = '0;
    if (state_q == StCheck) begin
      rej_res.reject_reason = (32'(step_q) < StickCount) ? RejStick : RejMapped;
    end else begin
      rej_res.reject_reason = early_rsn;
    end
  end

  assign v17      = 17'(rd_value_i);
  assign dz17     = {3'b000, dead_zone_i};
  assign in_range = rd_finite_i && (v17 >= -17'sd16386) && (v17 <= 17'sd16386);

  // dead-zone magnitude and rounded divide operands
  always_comb begin
    logic signed [16:0] m;
    m = '0;
    if (v17 > dz17) m = v17 - dz17;
    else if (v17 < -dz17) m = -dz17 - v17;
    mag     = 16'(m);
    div_den = 15'(OneQ14) - {1'b0, dead_zone_i};
    div_num = {mag[14:0], 14'd0} + 29'(div_den >> 1);
  end

  assign stick_val = (div_quo > 29'(OneQ14)) ? 16'(OneQ14) : div_quo[15:0];
  assign knob_sum  = 17'(v17 + 17'sd16384);
  assign knob      = knob_sum[16] ? 15'd0 : knob_sum[15:1];

  rcfc_divider u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  assign div_start   = (state_q == StRead) && (mag != 16'd0);
  assign res_valid_o = (state_q == StOut);
  assign res_o       = res_q;
  assign job_pop_o   = (state_q == StOut) && res_ready_i;

  assign pm  = mode_seen_q ? prev_mode_q : mode_val_q;
  assign pg  = gear_seen_q ? prev_gear_q : rd_value_i;
  assign hov = mode_val_q > mode_thr_i;
  assign off = hov && (rd_value_i > gear_thr_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      res_q       <= '0;
      prev_mode_q <= -16'sd16384;
      prev_gear_q <= -16'sd16384;
      mode_seen_q <= 1'b0;
      gear_seen_q <= 1'b0;
      mode_val_q  <= '0;
      neg_q       <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            step_q <= '0;
            if (early_rsn != RejNone) begin
              res_q <= rej_res;
              mode_seen_q <= 1'b0; gear_seen_q <= 1'b0;
              prev_mode_q <= -16'sd16384; prev_gear_q <= -16'sd16384;
              state_q <= StOut;
            end else begin
              res_q   <= '0;
              state_q <= StCheck;
            end
          end
        end
        StCheck: begin
          // range pass over the stick and mapped slots
          if (!in_range) begin
            res_q <= rej_res;
            mode_seen_q <= 1'b0; gear_seen_q <= 1'b0;
            prev_mode_q <= -16'sd16384; prev_gear_q <= -16'sd16384;
            state_q <= StOut;
          end else if (32'(step_q) == NSteps - 1) begin
            step_q  <= '0;
            state_q <= StRead;
          end else begin
            step_q <= step_q + StepW'(1);
          end
        end
        StRead: begin
          neg_q <= v17 < -dz17;
          if (32'(step_q) < StickCount) begin
            if (mag != 16'd0) state_q <= StDiv;
            else step_q <= step_q + StepW'(1);
          end else begin
            unique case (32'(step_q) - StickCount)
              0: res_q.p_level <= knob;
              1: res_q.i_level <= knob;
              2: res_q.d_level <= knob;
              3: mode_val_q <= rd_value_i;
              default: begin
                res_q.hover_active     <= hov;
                res_q.hover_entered    <= hov && (pm < mode_thr_i);
                res_q.offboard_active  <= off;
                res_q.offboard_entered <= off && (pg < gear_thr_i);
                prev_mode_q <= mode_val_q;
                prev_gear_q <= rd_value_i;
                mode_seen_q <= 1'b1;
                gear_seen_q <= 1'b1;
              end
            endcase
            if (32'(step_q) == NSteps - 1) state_q <= StOut;
            else step_q <= step_q + StepW'(1);
          end
        end
        StDiv: begin
          if (div_done) begin
            unique case (32'(step_q))
              0: res_q.stick_0 <= neg_q ? -stick_val : stick_val;
              1: res_q.stick_1 <= neg_q ? -stick_val : stick_val;
              2: res_q.stick_2 <= neg_q ? -stick_val : stick_val;
              3: res_q.stick_3 <= neg_q ? -stick_val : stick_val;
              default: ;
            endcase
            step_q  <= step_q + StepW'(1);
            state_q <= StRead;
          end
        end
        StOut: begin
          if (res_ready_i) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ===== rtl/rcfc_out_fifo.sv =====
// ----------------------------------------------------------------------------
// rcfc_out_fifo: two-entry result queue
// holds finished results until popped
// ----------------------------------------------------------------------------
module rcfc_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rcfc_pkg::out_item_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output rcfc_pkg::out_item_t data_o
);
  import rcfc_pkg::*;

  out_item_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wr_q <= ~wr_q;
      if (pop_i && !empty_o) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && !empty_o);
    end
  end
endmodule

// ===== rtl/rc_frame_conditioner.sv =====
// ----------------------------------------------------------------------------
// rc_frame_conditioner: radio-control frame checker and conditioner
// channel items fill a store; each frame end yields one checked result
// ----------------------------------------------------------------------------
// a channel item that does not close a frame is taken whenever the input is
// not full. a frame end is queued as a job and evaluated by the back end: it
// takes the job, makes a range pass over the stick and mapped slots, then a
// conditioning pass in which each non-zero stick runs the 29-step bit-serial
// divider while a zero stick and each mapped slot take a single step, and
// then hands over the result; a rejected frame ends its passes early.
// the channel store is written by the front end only while no job is pending,
// so the input stays full from the cycle after a frame end until its result
// has gone into the result queue
module rc_frame_conditioner #(
  parameter int unsigned MaxChannels = 18,
  parameter int unsigned StickCount  = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // item side
  input  logic                 push,
  output logic                 full,
  input  rcfc_pkg::in_item_t   in_item_i,
  // result side
  output logic                 empty,
  input  logic                 pop,
  output rcfc_pkg::out_item_t  out_item_o,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i
);
  import rcfc_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxChannels);

  // configuration registers
  logic [13:0]        dead_zone_q;
  logic signed [15:0] mode_thr_q, gear_thr_q;
  logic [4:0]         p_chan_q, i_chan_q, d_chan_q, mode_chan_q, gear_chan_q;

  // channel store: value and finite bit per slot
  logic signed [15:0] store_val_q [MaxChannels];
  logic               store_fin_q [MaxChannels];

  logic               accept;
  logic               job_full, job_empty, job_pop;
  job_t               job_in, job_out;
  logic [IdxW-1:0]    rd_idx;
  logic               res_valid, res_full;
  out_item_t          res;

  // stall new items while a frame is being evaluated so the store stays put
  assign full   = job_full || !job_empty;
  assign accept = push && !full;

  assign job_in.lost  = in_item_i.link_lost;
  assign job_in.count = in_item_i.claimed_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q <= 14'd1638;
      mode_thr_q  <= 16'sd8192;
      gear_thr_q  <= 16'sd8192;
      p_chan_q    <= 5'd5;
      i_chan_q    <= 5'd6;
      d_chan_q    <= 5'd7;
      mode_chan_q <= 5'd4;
      gear_chan_q <= 5'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegDeadZone: dead_zone_q <= cfg_data_i[13:0];
        RegModeThr:  mode_thr_q  <= cfg_data_i;
        RegGearThr:  gear_thr_q  <= cfg_data_i;
        RegPChan:    p_chan_q    <= cfg_data_i[4:0];
        RegIChan:    i_chan_q    <= cfg_data_i[4:0];
        RegDChan:    d_chan_q    <= cfg_data_i[4:0];
        RegModeChan: mode_chan_q <= cfg_data_i[4:0];
        default:     gear_chan_q <= cfg_data_i[4:0];
      endcase
    end
  end

  // store write on every accepted item with an in-range slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxChannels; k++) begin
        store_val_q[k] <= '0;
        store_fin_q[k] <= 1'b1;
      end
    end else if (accept && 32'(in_item_i.channel_index) < MaxChannels) begin
      store_val_q[IdxW'(in_item_i.channel_index)] <= in_item_i.channel_value;
      store_fin_q[IdxW'(in_item_i.channel_index)] <= in_item_i.value_finite;
    end
  end

  rcfc_job_fifo u_jobs (
    .clk_i, .rst_ni,
    .push_i(accept && in_item_i.frame_end), .data_i(job_in), .full_o(job_full),
    .pop_i(job_pop), .empty_o(job_empty), .data_o(job_out)
  );

  rcfc_evaluator #(.MaxChannels(MaxChannels), .StickCount(StickCount)) u_eval (
    .clk_i, .rst_ni,
    .job_valid_i(!job_empty && !res_full), .job_i(job_out), .job_pop_o(job_pop),
    .rd_idx_o(rd_idx),
    .rd_value_i(store_val_q[rd_idx]), .rd_finite_i(store_fin_q[rd_idx]),
    .dead_zone_i(dead_zone_q), .mode_thr_i(mode_thr_q), .gear_thr_i(gear_thr_q),
    .p_chan_i(p_chan_q), .i_chan_i(i_chan_q), .d_chan_i(d_chan_q),
    .mode_chan_i(mode_chan_q), .gear_chan_i(gear_chan_q),
    .res_valid_o(res_valid), .res_o(res), .res_ready_i(!res_full)
  );

  rcfc_out_fifo u_results (
    .clk_i, .rst_ni,
    .push_i(res_valid), .data_i(res), .full_o(res_full),
    .pop_i(pop), .empty_o(empty), .data_o(out_item_o)
  );
endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the rc frame conditioner
// drives channel items through the push side, mirrors the block in a local
// frame model and compares every popped result field by field with it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import rcfc_pkg::*;

  localparam int NumSlots  = 18;
  localparam int NumSticks = 4;
  localparam int TargetItems = 1900;
  localparam int InBits = $bits(in_item_t);

  logic      clk;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_data;

  rc_frame_conditioner dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // local copy of the block: registers, channel store and switch history
  int unsigned dz_width;
  int          mode_thr;
  int          gear_thr;
  int unsigned knob_chan [3];
  int unsigned mode_chan;
  int unsigned gear_chan;
  int          slot_val [NumSlots];
  bit          slot_fin [NumSlots];
  int          hist_mode;
  int          hist_gear;
  bit          mode_known;
  bit          gear_known;

  out_item_t frame_results[$];
  int        errors;
  int        items_sent;
  int        frames_closed;
  int        results_seen;
  int        reject_hist [6];
  int        burst_left;
  logic      rx_hold;
  int        rx_rate;
  int        rx_phase;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // frame model
  // ---------------------------------------------------------------------------

  // dead zone with round half away from zero and saturation to one
  function automatic int dead_zoned(int v);
    longint mag;
    longint den;
    longint q;
    bit     neg;
    if (v > int'(dz_width)) begin
      mag = v - int'(dz_width);
      neg = 1'b0;
    end else if (v < -int'(dz_width)) begin
      mag = -int'(dz_width) - v;
      neg = 1'b1;
    end else begin
      return 0;
    end
    den = OneQ14 - dz_width;
    q = (mag * OneQ14 + den / 2) / den;
    if (q > OneQ14) q = OneQ14;
    return neg ? -int'(q) : int'(q);
  endfunction

  // knob position mapped onto zero through one
  function automatic int knob_level(int v);
    int s;
    s = v + int'(OneQ14);
    return (s < 0) ? 0 : (s >>> 1);
  endfunction

  function automatic bit slot_in_range(int unsigned idx);
    if (idx >= NumSlots) return 1'b0;
    return slot_fin[idx] && slot_val[idx] >= -int'(RangeLimit) &&
           slot_val[idx] <= int'(RangeLimit);
  endfunction

  // applies one accepted item; a frame end queues the expected result
  function automatic void condition_frame(in_item_t it);
    out_item_t   r;
    int unsigned mapped [5];
    int unsigned need;
    logic [2:0]  why;
    int          mode;
    int          gear;
    bit          hv;
    bit          ob;
    if (it.channel_index < NumSlots) begin
      slot_val[it.channel_index] = it.channel_value;
      slot_fin[it.channel_index] = it.value_finite;
    end
    if (!it.frame_end) return;
    frames_closed++;
    r = '0;
    why = RejNone;
    need = NumSticks;
    mapped[0] = knob_chan[0];
    mapped[1] = knob_chan[1];
    mapped[2] = knob_chan[2];
    mapped[3] = mode_chan;
    mapped[4] = gear_chan;
    if (it.link_lost) begin
      why = RejLost;
    end else begin
      foreach (mapped[k]) begin
        if (why == RejNone) begin
          if (mapped[k] >= NumSlots) why = RejIndex;
          else if (mapped[k] + 1 > need) need = mapped[k] + 1;
        end
      end
    end
    if (why == RejNone && (it.claimed_count > NumSlots || it.claimed_count < need))
      why = RejCount;
    for (int k = 0; k < NumSticks; k++)
      if (why == RejNone && !slot_in_range(k)) why = RejStick;
    foreach (mapped[k])
      if (why == RejNone && !slot_in_range(mapped[k])) why = RejMapped;
    reject_hist[why]++;
    if (why != RejNone) begin
      // rejected frame wipes the switch history but keeps the store
      hist_mode = -int'(OneQ14);
      hist_gear = -int'(OneQ14);
      mode_known = 1'b0;
      gear_known = 1'b0;
      r.reject_reason = why;
      frame_results.push_back(r);
      return;
    end
    r.stick_0 = 16'(dead_zoned(slot_val[0]));
    r.stick_1 = 16'(dead_zoned(slot_val[1]));
    r.stick_2 = 16'(dead_zoned(slot_val[2]));
    r.stick_3 = 16'(dead_zoned(slot_val[3]));
    r.p_level = 15'(knob_level(slot_val[knob_chan[0]]));
    r.i_level = 15'(knob_level(slot_val[knob_chan[1]]));
    r.d_level = 15'(knob_level(slot_val[knob_chan[2]]));
    mode = slot_val[mode_chan];
    gear = slot_val[gear_chan];
    // no history yet: treat the previous level as the current one
    if (!mode_known) begin
      hist_mode = mode;
      mode_known = 1'b1;
    end
    if (!gear_known) begin
      hist_gear = gear;
      gear_known = 1'b1;
    end
    hv = mode > mode_thr;
    ob = hv && gear > gear_thr;
    r.hover_active     = hv;
    r.hover_entered    = hv && hist_mode < mode_thr;
    r.offboard_active  = ob;
    r.offboard_entered = ob && hist_gear < gear_thr;
    hist_mode = mode;
    hist_gear = gear;
    frame_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: compare each transfer, stall on a pattern of its own
  // ---------------------------------------------------------------------------

  task automatic check_field(string nm, int exp_v, int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t ns mismatch %s: expected %0d actual %0d", $time, nm, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst_ni && pop && !empty) begin
      results_seen++;
      if (frame_results.size() == 0) begin
        errors++;
        $display("%0t ns unexpected result transfer: expected none actual %p",
                 $time, out_item);
      end else begin
        e = frame_results.pop_front();
        check_field("reject_reason", e.reject_reason, out_item.reject_reason);
        check_field("stick_0", e.stick_0, out_item.stick_0);
        check_field("stick_1", e.stick_1, out_item.stick_1);
        check_field("stick_2", e.stick_2, out_item.stick_2);
        check_field("stick_3", e.stick_3, out_item.stick_3);
        check_field("p_level", e.p_level, out_item.p_level);
        check_field("i_level", e.i_level, out_item.i_level);
        check_field("d_level", e.d_level, out_item.d_level);
        check_field("hover_active", e.hover_active, out_item.hover_active);
        check_field("hover_entered", e.hover_entered, out_item.hover_entered);
        check_field("offboard_active", e.offboard_active, out_item.offboard_active);
        check_field("offboard_entered", e.offboard_entered, out_item.offboard_entered);
      end
    end
    // receiver pattern: rx_phase switches it among eager, patchy and sluggish
    rx_phase++;
    if (rx_phase % 64 == 0) begin
      case ($urandom_range(0, 2))
        0: rx_rate = 100;
        1: rx_rate = 60;
        default: rx_rate = 15;
      endcase
    end
    pop <= !rx_hold && ($urandom_range(0, 99) < rx_rate);
  end

  // ---------------------------------------------------------------------------
  // item side
  // ---------------------------------------------------------------------------

  // one item transfer; bursts of random length separated by random gaps
  task automatic send_item(in_item_t it);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    condition_frame(it);
  endtask

  // stop sending, let every result drain and the back end settle
  task automatic drain;
    push <= 1'b0;
    burst_left = 0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // register write, mirrored into the model; call only when idle
  task automatic reg_write(logic [2:0] idx, logic [15:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      RegDeadZone: dz_width = data[13:0];
      RegModeThr:  mode_thr = $signed(data);
      RegGearThr:  gear_thr = $signed(data);
      RegPChan:    knob_chan[0] = data[4:0];
      RegIChan:    knob_chan[1] = data[4:0];
      RegDChan:    knob_chan[2] = data[4:0];
      RegModeChan: mode_chan = data[4:0];
      default:     gear_chan = data[4:0];
    endcase
    cfg_we <= 1'b0;
  endtask

  // single-item frame: writes one slot and closes the frame
  function automatic in_item_t one_shot(int idx, int val, bit fin = 1'b1,
                                        bit lost = 1'b0, int cnt = NumSlots);
    in_item_t it;
    it.channel_index = 5'(idx);
    it.channel_value = 16'(val);
    it.value_finite  = fin;
    it.link_lost     = lost;
    it.claimed_count = 5'(cnt);
    it.frame_end     = 1'b1;
    return it;
  endfunction

  // slot value: switch slots hover around their thresholds, rest mostly legal
  function automatic int slot_pick(int unsigned idx);
    int thr;
    if (idx == mode_chan || idx == gear_chan) begin
      thr = (idx == mode_chan) ? mode_thr : gear_thr;
      case ($urandom_range(0, 5))
        0: return thr;
        1: return thr + 1;
        2: return thr - 1;
        3: return -int'(OneQ14);
        4: return int'(OneQ14);
        default: return int'($urandom_range(0, 32768)) - int'(OneQ14);
      endcase
    end
    if ($urandom_range(0, 49) == 0) return $signed(16'($urandom));
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(0, 1) ? int'(RangeLimit) : -int'(RangeLimit);
    return int'($urandom_range(0, 2 * RangeLimit)) - int'(RangeLimit);
  endfunction

  // smallest count the current mapping accepts
  function automatic int count_needed();
    int n;
    n = NumSticks;
    foreach (knob_chan[k]) if (knob_chan[k] < NumSlots && knob_chan[k] + 1 > n)
      n = knob_chan[k] + 1;
    if (mode_chan < NumSlots && mode_chan + 1 > n) n = mode_chan + 1;
    if (gear_chan < NumSlots && gear_chan + 1 > n) n = gear_chan + 1;
    return n;
  endfunction

  // a well-formed frame with random content, now and then spoilt; or noise
  task automatic random_frame;
    in_item_t it;
    int       cnt;
    int       roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      // noise item: every field random, slot index may be out of range
      it = in_item_t'(InBits'({$urandom, $urandom}));
      it.frame_end = ($urandom_range(0, 2) == 0);
      send_item(it);
    end else begin
      cnt = count_needed();
      for (int s = 0; s < cnt; s++) begin
        it.channel_index = 5'(s);
        it.channel_value = 16'(slot_pick(s));
        it.value_finite  = ($urandom_range(0, 59) != 0);
        it.link_lost     = 1'($urandom);
        it.claimed_count = 5'($urandom);
        it.frame_end     = (s == cnt - 1);
        if (it.frame_end) begin
          it.link_lost     = ($urandom_range(0, 29) == 0);
          it.claimed_count = 5'(cnt);
          if (roll < 18) it.claimed_count = 5'($urandom);
          else if (roll < 40) it.claimed_count = 5'($urandom_range(cnt, NumSlots));
        end
        send_item(it);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes of the fields and every reject reason but the index one at reset settings
  task automatic test_directed;
    in_item_t it;
    send_item(one_shot(0, OneQ14));
    send_item(one_shot(1, -int'(OneQ14)));
    send_item(one_shot(4, OneQ14));           // hover entry
    send_item(one_shot(8, OneQ14));           // offboard entry
    send_item(one_shot(3, RangeLimit));       // range edge still accepted
    send_item(one_shot(3, -int'(RangeLimit)));
    send_item(one_shot(4, OneQ14, 1'b1, 1'b1)); // signal lost
    send_item(one_shot(4, 8192));             // equal to threshold, no entry
    send_item(one_shot(4, OneQ14, 1'b1, 1'b0, 31)); // count too high
    send_item(one_shot(4, OneQ14, 1'b1, 1'b0, 8));  // count too low
    send_item(one_shot(4, OneQ14, 1'b1, 1'b0, 0));
    send_item(one_shot(2, RangeLimit + 1));   // stick out of range
    send_item(one_shot(2, 0, 1'b0));          // stick not finite
    send_item(one_shot(2, 0));
    send_item(one_shot(5, -32768));           // mapped out of range
    send_item(one_shot(5, 32767));
    send_item(one_shot(7, 0, 1'b0));          // mapped not finite
    send_item(one_shot(7, -int'(OneQ14)));
    send_item(one_shot(5, 0));
    // unframed item, then a frame closed on an unused slot index
    it = one_shot(6, 8000);
    it.frame_end = 1'b0;
    send_item(it);
    send_item(one_shot(31, -1, 1'b0, 1'b0, 9));
    send_item(one_shot(0, 1638));             // inside dead zone
    send_item(one_shot(0, 1639));
    drain();
  endtask

  // register extremes: dead zone and thresholds
  task automatic test_register_extremes;
    reg_write(RegDeadZone, 16'd0);
    reg_write(RegModeThr, 16'(-16384));
    reg_write(RegGearThr, 16'd16384);
    repeat (8) random_frame();
    drain();
    reg_write(RegDeadZone, 16'd16383);
    reg_write(RegModeThr, 16'd16384);
    reg_write(RegGearThr, 16'(-16384));
    repeat (8) random_frame();
    drain();
  endtask

  // channel mapping: top slot, an out-of-range index and the defaults back
  task automatic test_channel_map;
    reg_write(RegPChan, 16'd17);
    reg_write(RegIChan, 16'd0);
    reg_write(RegDChan, 16'd3);
    reg_write(RegModeChan, 16'd16);
    reg_write(RegGearChan, 16'd9);
    repeat (6) random_frame();
    drain();
    reg_write(RegGearChan, 16'd31);           // configured index rejected
    repeat (4) random_frame();
    drain();
    reg_write(RegDeadZone, 16'd1638);
    reg_write(RegModeThr, 16'd8192);
    reg_write(RegGearThr, 16'd8192);
    reg_write(RegPChan, 16'd5);
    reg_write(RegIChan, 16'd6);
    reg_write(RegDChan, 16'd7);
    reg_write(RegModeChan, 16'd4);
    reg_write(RegGearChan, 16'd8);
  endtask

  // receiver holds off a long while so the block fills and stalls its input
  task automatic test_back_pressure;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (4000) @(posedge clk);
        rx_hold <= 1'b0;
      end
      begin
        repeat (40) send_item(one_shot($urandom_range(0, 17), slot_pick(0)));
      end
    join
    drain();
  endtask

  // random frames in four phases, each after the first with fresh register settings
  task automatic test_random;
    int stop_at;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) begin
        reg_write(RegDeadZone, 16'($urandom_range(0, 16383)));
        reg_write(RegModeThr, 16'(int'($urandom_range(0, 32768)) - 16384));
        reg_write(RegGearThr, 16'(int'($urandom_range(0, 32768)) - 16384));
        reg_write(RegPChan, 16'($urandom_range(0, 17)));
        reg_write(RegIChan, 16'($urandom_range(0, 17)));
        reg_write(RegDChan, 16'($urandom_range(0, 17)));
        reg_write(RegModeChan, 16'($urandom_range(0, 17)));
        reg_write(RegGearChan, 16'($urandom_range(0, ph == 3 ? 19 : 17)));
      end
      // spread what is left of the item budget over the remaining phases
      stop_at = items_sent + (TargetItems - items_sent) / (4 - ph);
      while (items_sent < stop_at) random_frame();
      drain();
    end
  endtask

  initial begin
    rst_ni   = 1'b0;
    push     = 1'b0;
    pop      = 1'b0;
    in_item  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    rx_hold  = 1'b0;
    rx_rate  = 100;
    rx_phase = 0;
    errors = 0;
    items_sent = 0;
    frames_closed = 0;
    results_seen = 0;
    burst_left = 0;
    dz_width = 1638;
    mode_thr = 8192;
    gear_thr = 8192;
    knob_chan = '{5, 6, 7};
    mode_chan = 4;
    gear_chan = 8;
    foreach (slot_val[k]) begin
      slot_val[k] = 0;
      slot_fin[k] = 1'b1;
    end
    hist_mode = -int'(OneQ14);
    hist_gear = -int'(OneQ14);
    mode_known = 1'b0;
    gear_known = 1'b0;
    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk);

    test_directed();
    test_register_extremes();
    test_channel_map();
    test_back_pressure();
    test_random();

    $display("covered %0d items, %0d frames, %0d results checked", items_sent,
             frames_closed, results_seen);
    $display("outcomes ok/lost/index/count/stick/mapped: %0d/%0d/%0d/%0d/%0d/%0d",
             reject_hist[0], reject_hist[1], reject_hist[2], reject_hist[3],
             reject_hist[4], reject_hist[5]);
    if (errors == 0 && frame_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
